// ===== hdl/lbd_pkg.sv =====
// Shared types, codes and the percent reciprocal table for the LED blink controller.
package lbd_pkg;

  // Command codes on the func field
  typedef enum logic [2:0] {
    FUNC_SET    = 3'd0,
    FUNC_BLINK  = 3'd1,
    FUNC_UPDATE = 3'd2,
    FUNC_SLEEP  = 3'd3,
    FUNC_WAKE   = 3'd4
  } func_e;

  // Sub-commands of a set command
  typedef enum logic [2:0] {
    SM_OFF    = 3'd0,
    SM_ON     = 3'd1,
    SM_TOGGLE = 3'd2,
    SM_BLINK  = 3'd3,
    SM_FLASH  = 3'd4
  } set_mode_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DUTY   = 2'd0,
    CFG_PERIOD = 2'd1,
    CFG_COUNT  = 2'd2
  } cfg_reg_e;

  // Operation seen by every lane after decode
  typedef enum logic [2:0] {
    LOP_NONE   = 3'd0,
    LOP_OFF    = 3'd1,
    LOP_ON     = 3'd2,
    LOP_TOGGLE = 3'd3,
    LOP_BLINK  = 3'd4,
    LOP_UPDATE = 3'd5,
    LOP_SLEEP  = 3'd6
  } lane_op_e;

  localparam int unsigned PCT_W       = 7;
  localparam int unsigned PCT_FULL    = 100;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned WAIT_W      = 16;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned RECIP_SHIFT = 23;
  localparam int unsigned RECIP_W     = RECIP_SHIFT;
  localparam int unsigned PROD_W      = PERIOD_W + RECIP_W;

  localparam logic [PCT_W-1:0]      DUTY_RST   = 7'd5;
  localparam logic [PERIOD_W-1:0]   PERIOD_RST = 16'd1000;
  localparam logic [COUNT_W-1:0]    COUNT_RST  = 8'd50;
  localparam logic [PCT_W-1:0]      PCT_HUNDRED = 7'd100;
  localparam logic [WAIT_W-1:0]     WAIT_MAX   = 16'hFFFF;

  // Per-LED mode: continuous flag, blinking flag, on flag
  typedef struct packed {
    logic cont;
    logic blink;
    logic on;
  } lane_mode_t;

  // Command broadcast to the lanes
  typedef struct packed {
    lane_op_e              op;
    logic [COUNT_W-1:0]    count;
    logic [PCT_W-1:0]      pct;
    logic [PERIOD_W-1:0]   period;
    logic [TIME_W-1:0]     now;
  } lane_cmd_t;

  // What one lane reports for an item
  typedef struct packed {
    logic              pin;
    logic              lit;
    logic [WAIT_W-1:0] wait_ms;
  } lane_res_t;

  // ceil(p * 2^23 / 100): period * entry >> 23 equals floor(p * period / 100)
  // exactly for p up to 99 and any 16-bit period.
  typedef logic [RECIP_W-1:0] recip_tab_t [2**PCT_W];

  function automatic recip_tab_t build_recip();
    recip_tab_t tab;
    longint     num;
    for (int i = 0; i < 2**PCT_W; i++) begin
      num = (longint'(i) << RECIP_SHIFT) + longint'(PCT_FULL - 1);
      if (i < PCT_FULL) begin
        tab[i] = RECIP_W'(num / PCT_FULL);
      end else begin
        tab[i] = '0;
      end
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP_TAB = build_recip();

endpackage

// ===== hdl/lbd_lane.sv =====
// One LED lane: mode, counters and timing of a single LED and its next-state logic.
module lbd_lane (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic              sel_i,
  input  lbd_pkg::lane_cmd_t cmd_i,
  output lbd_pkg::lane_res_t res_o
);

  lbd_pkg::lane_mode_t mode_q, mode_d;
  logic [lbd_pkg::COUNT_W-1:0]  left_q, left_d;
  logic [lbd_pkg::WAIT_W-1:0]   on_wait_q, on_wait_d;
  logic [lbd_pkg::WAIT_W-1:0]   off_wait_q, off_wait_d;
  logic [lbd_pkg::TIME_W-1:0]   next_q, next_d;
  logic pin_q, pin_d;
  logic lit_q, lit_d;
  logic pre_q, pre_d;

  logic [lbd_pkg::PROD_W-1:0]   on_prod, off_prod;
  logic [lbd_pkg::PCT_W-1:0]    off_pct;
  logic [lbd_pkg::TIME_W-1:0]   remain;
  logic [lbd_pkg::WAIT_W-1:0]   wait_ms;
  logic                         due;

  // Scale the period by the on and off shares for a new blink
  assign off_pct  = lbd_pkg::PCT_HUNDRED - cmd_i.pct;
  assign on_prod  = lbd_pkg::PROD_W'(cmd_i.period)
                  * lbd_pkg::PROD_W'(lbd_pkg::RECIP_TAB[cmd_i.pct]);
  assign off_prod = lbd_pkg::PROD_W'(cmd_i.period)
                  * lbd_pkg::PROD_W'(lbd_pkg::RECIP_TAB[off_pct]);

  // Time until the next change, saturated to the wait width
  assign due    = cmd_i.now >= next_q;
  assign remain = next_q - cmd_i.now;

  // Next state of the lane for the current command
  always_comb begin
    mode_d     = mode_q;
    left_d     = left_q;
    on_wait_d  = on_wait_q;
    off_wait_d = off_wait_q;
    next_d     = next_q;
    pin_d      = pin_q;
    lit_d      = lit_q;
    pre_d      = pre_q;
    wait_ms    = '0;
    case (cmd_i.op)
      lbd_pkg::LOP_OFF, lbd_pkg::LOP_ON, lbd_pkg::LOP_TOGGLE: begin
        if (sel_i) begin
          if (cmd_i.op == lbd_pkg::LOP_TOGGLE) begin
            mode_d.on = ~mode_q.on;
          end else begin
            mode_d    = '0;
            mode_d.on = (cmd_i.op == lbd_pkg::LOP_ON);
          end
          pin_d = mode_d.on && !mode_d.blink && !mode_d.cont;
          lit_d = |mode_d;
        end
      end
      lbd_pkg::LOP_BLINK: begin
        if (sel_i) begin
          if (!mode_q.blink && !mode_q.cont) begin
            pre_d = pre_q | lit_q;
          end
          mode_d.cont  = (cmd_i.count == '0);
          mode_d.blink = 1'b1;
          mode_d.on    = 1'b0;
          left_d       = cmd_i.count;
          on_wait_d    = on_prod[lbd_pkg::PROD_W-1:lbd_pkg::RECIP_SHIFT];
          off_wait_d   = off_prod[lbd_pkg::PROD_W-1:lbd_pkg::RECIP_SHIFT];
          next_d       = cmd_i.now;
        end
      end
      lbd_pkg::LOP_SLEEP: begin
        pin_d = 1'b0;
        lit_d = 1'b0;
      end
      lbd_pkg::LOP_UPDATE: begin
        if (mode_q.blink) begin
          if (due) begin
            if (mode_q.on) begin
              // end of the on phase
              mode_d.on = 1'b0;
              pin_d     = 1'b0;
              lit_d     = 1'b0;
              if (!mode_q.cont) begin
                left_d = left_q - lbd_pkg::COUNT_W'(1'b1);
              end
              wait_ms = off_wait_q;
              next_d  = cmd_i.now + lbd_pkg::TIME_W'(off_wait_q);
            end else if (left_q == '0 && !mode_q.cont) begin
              // blink done: restore the state held before it began
              mode_d    = '0;
              mode_d.on = pre_q;
              pin_d     = pre_q;
              lit_d     = pre_q;
              pre_d     = 1'b0;
            end else begin
              mode_d.on = 1'b1;
              pin_d     = 1'b1;
              lit_d     = 1'b1;
              wait_ms   = on_wait_q;
              next_d    = cmd_i.now + lbd_pkg::TIME_W'(on_wait_q);
            end
          end else begin
            wait_ms = (|remain[lbd_pkg::TIME_W-1:lbd_pkg::WAIT_W]) ? lbd_pkg::WAIT_MAX
                                                                  : remain[lbd_pkg::WAIT_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Report the post-item levels and this lane's wait
  always_comb begin
    res_o.pin     = pin_d;
    res_o.lit     = lit_d;
    res_o.wait_ms = wait_ms;
  end

  // Advance lane state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= '0;
      left_q     <= '0;
      on_wait_q  <= '0;
      off_wait_q <= '0;
      next_q     <= '0;
      pin_q      <= 1'b0;
      lit_q      <= 1'b0;
      pre_q      <= 1'b0;
    end else if (take_i) begin
      mode_q     <= mode_d;
      left_q     <= left_d;
      on_wait_q  <= on_wait_d;
      off_wait_q <= off_wait_d;
      next_q     <= next_d;
      pin_q      <= pin_d;
      lit_q      <= lit_d;
      pre_q      <= pre_d;
    end
  end

endmodule

// ===== hdl/lbd_merge.sv =====
// Merge stage: registers lane results, picks the shortest nonzero wait, holds the output item.
module lbd_merge #(
  parameter int unsigned NUM_LEDS = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        take_i,
  input  logic                        cancel_i,
  input  lbd_pkg::lane_res_t          lane_res_i [NUM_LEDS],
  output logic                        in_stall_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [NUM_LEDS-1:0]         led_drive_o,
  output logic [NUM_LEDS-1:0]         led_state_o,
  output logic                        timer_cancel_o,
  output logic                        timer_start_o,
  output logic [lbd_pkg::WAIT_W-1:0]  next_wait_ms_o
);

  logic                s1_valid_q, s1_valid_d;
  lbd_pkg::lane_res_t  s1_res_q [NUM_LEDS];
  logic                s1_cancel_q;
  logic                out_valid_q, out_valid_d;
  logic                out_adv;

  logic [NUM_LEDS-1:0]          drive;
  logic [NUM_LEDS-1:0]          lit;
  logic [lbd_pkg::WAIT_W:0]     best;
  logic [lbd_pkg::WAIT_W:0]     key;

  logic [NUM_LEDS-1:0]          drive_q;
  logic [NUM_LEDS-1:0]          lit_q;
  logic                         cancel_q;
  logic [lbd_pkg::WAIT_W-1:0]   wait_q;

  // Output register moves when empty or taken
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_adv;

  // Hold stage one until the output register frees up
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (take_i) begin
      s1_valid_d = 1'b1;
    end else if (out_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_adv ? s1_valid_q : out_valid_q;
  end

  // Shortest nonzero wait over the lanes; a zero wait ranks below every real one
  always_comb begin
    best = {1'b1, {lbd_pkg::WAIT_W{1'b0}}};
    key  = '0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      drive[i] = s1_res_q[i].pin;
      lit[i]   = s1_res_q[i].lit;
      key = (s1_res_q[i].wait_ms == '0) ? {1'b1, {lbd_pkg::WAIT_W{1'b0}}}
                                        : {1'b0, s1_res_q[i].wait_ms};
      if (key < best) begin
        best = key;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture lane results of an accepted item
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      s1_res_q    <= lane_res_i;
      s1_cancel_q <= cancel_i;
    end
  end

  // Load the output item
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_adv) begin
      drive_q  <= drive;
      lit_q    <= lit;
      cancel_q <= s1_cancel_q;
      wait_q   <= best[lbd_pkg::WAIT_W] ? '0 : best[lbd_pkg::WAIT_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign led_drive_o    = drive_q;
  assign led_state_o    = lit_q;
  assign timer_cancel_o = cancel_q;
  assign timer_start_o  = (wait_q != '0);
  assign next_wait_ms_o = wait_q;

endmodule

// ===== hdl/led_blink_duty_controller.sv =====
// Top level of the LED blink controller: decode, configuration, lanes and merge stage.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one command item per cycle:
//   set, blink, update, enter sleep or exit sleep, with its mask, blink
//   parameters and the current time in ms. Output channel (out_valid_o /
//   out_stall_i) returns exactly one item per command: pin levels, remembered
//   state bits, the timer cancel flag and, for update, the shortest wait.
//   Each LED has its own lane; all lanes work on the same item in parallel
//   and a merge stage reduces their waits.
//   Path: an accepted item is held in the stage register and then in the
//   output register.
//   Throughput: one item per cycle unless stalled, set by the lane next-state
//   logic, whose single 16x23 multiply per share serves blink commands only.
//   Stall: the output register and the stage behind it keep two items; with
//   both full and out_stall_i high, in_stall_o rises and the lanes hold.
//   Reset: all LEDs off, no blinking, awake, defaults 5 %, 1000 ms, 50 flashes.
//   Configuration writes (cfg_we_i) take effect at once; write them while idle.
module led_blink_duty_controller #(
  parameter int unsigned NUM_LEDS = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_index_i,
  input  logic [lbd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // command items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     func_i,
  input  logic [NUM_LEDS-1:0]            led_mask_i,
  input  logic [2:0]                     set_mode_i,
  input  logic [lbd_pkg::COUNT_W-1:0]    blink_count_i,
  input  logic [7:0]                     duty_percent_i,
  input  logic [lbd_pkg::PERIOD_W-1:0]   period_ms_i,
  input  logic [lbd_pkg::TIME_W-1:0]     now_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [NUM_LEDS-1:0]            led_drive_o,
  output logic [NUM_LEDS-1:0]            led_state_o,
  output logic                           timer_cancel_o,
  output logic                           timer_start_o,
  output logic [lbd_pkg::WAIT_W-1:0]     next_wait_ms_o
);

  logic [lbd_pkg::PCT_W-1:0]    duty_q;
  logic [lbd_pkg::PERIOD_W-1:0] period_q;
  logic [lbd_pkg::COUNT_W-1:0]  count_q;
  logic                         sleeping_q, sleeping_d;

  logic                         take;
  logic                         is_blink;
  logic [7:0]                   blk_pct;
  logic [lbd_pkg::PERIOD_W-1:0] blk_period;
  logic [lbd_pkg::COUNT_W-1:0]  blk_count;
  logic                         cancel;
  lbd_pkg::lane_cmd_t           cmd;
  lbd_pkg::lane_res_t           lane_res [NUM_LEDS];

  assign take = in_valid_i && !in_stall_o;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q   <= lbd_pkg::DUTY_RST;
      period_q <= lbd_pkg::PERIOD_RST;
      count_q  <= lbd_pkg::COUNT_RST;
    end else if (cfg_we_i) begin
      case (lbd_pkg::cfg_reg_e'(cfg_index_i))
        lbd_pkg::CFG_DUTY:   duty_q   <= cfg_wdata_i[lbd_pkg::PCT_W-1:0];
        lbd_pkg::CFG_PERIOD: period_q <= cfg_wdata_i[lbd_pkg::PERIOD_W-1:0];
        lbd_pkg::CFG_COUNT:  count_q  <= cfg_wdata_i[lbd_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pick blink parameters: explicit or the defaults
  always_comb begin
    is_blink   = 1'b0;
    blk_pct    = duty_percent_i;
    blk_period = period_ms_i;
    blk_count  = blink_count_i;
    case (lbd_pkg::func_e'(func_i))
      lbd_pkg::FUNC_BLINK: is_blink = 1'b1;
      lbd_pkg::FUNC_SET: begin
        if (set_mode_i inside {lbd_pkg::SM_BLINK, lbd_pkg::SM_FLASH}) begin
          is_blink   = 1'b1;
          blk_pct    = {1'b0, duty_q};
          blk_period = period_q;
          blk_count  = (set_mode_i == lbd_pkg::SM_FLASH) ? count_q : 8'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Decode the item into one lane operation
  always_comb begin
    cmd.op     = lbd_pkg::LOP_NONE;
    cmd.count  = blk_count;
    cmd.pct    = blk_pct[lbd_pkg::PCT_W-1:0];
    cmd.period = blk_period;
    cmd.now    = now_i;
    cancel     = 1'b0;
    sleeping_d = sleeping_q;
    if (is_blink) begin
      if (led_mask_i == '0 || blk_pct == '0 || blk_period == '0) begin
        cmd.op = lbd_pkg::LOP_OFF;
      end else if (blk_pct >= 8'(lbd_pkg::PCT_FULL)) begin
        cmd.op = lbd_pkg::LOP_ON;
      end else begin
        cmd.op = lbd_pkg::LOP_BLINK;
        cancel = 1'b1;
      end
    end else begin
      case (lbd_pkg::func_e'(func_i))
        lbd_pkg::FUNC_SET: begin
          case (lbd_pkg::set_mode_e'(set_mode_i))
            lbd_pkg::SM_OFF:    cmd.op = lbd_pkg::LOP_OFF;
            lbd_pkg::SM_ON:     cmd.op = lbd_pkg::LOP_ON;
            lbd_pkg::SM_TOGGLE: cmd.op = lbd_pkg::LOP_TOGGLE;
            default:            cmd.op = lbd_pkg::LOP_NONE;
          endcase
        end
        lbd_pkg::FUNC_UPDATE: begin
          cmd.op = sleeping_q ? lbd_pkg::LOP_NONE : lbd_pkg::LOP_UPDATE;
        end
        lbd_pkg::FUNC_SLEEP: begin
          cmd.op     = lbd_pkg::LOP_SLEEP;
          sleeping_d = 1'b1;
        end
        lbd_pkg::FUNC_WAKE: begin
          sleeping_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sleeping_q <= 1'b0;
    end else if (take) begin
      sleeping_q <= sleeping_d;
    end
  end

  // One lane per LED
  for (genvar g = 0; g < NUM_LEDS; g++) begin : g_lane
    lbd_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .take_i (take),
      .sel_i  (led_mask_i[g]),
      .cmd_i  (cmd),
      .res_o  (lane_res[g])
    );
  end

  lbd_merge #(
    .NUM_LEDS (NUM_LEDS)
  ) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .cancel_i       (cancel),
    .lane_res_i     (lane_res),
    .in_stall_o     (in_stall_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .led_drive_o    (led_drive_o),
    .led_state_o    (led_state_o),
    .timer_cancel_o (timer_cancel_o),
    .timer_start_o  (timer_start_o),
    .next_wait_ms_o (next_wait_ms_o)
  );

endmodule

// ===== hdl/lbd_checker.sv =====
// Port-level checks of the LED blink controller and their binding to the top level.
module lbd_checker #(
  parameter int unsigned NUM_LEDS = 3
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [NUM_LEDS-1:0]           led_drive_o,
  input logic [NUM_LEDS-1:0]           led_state_o,
  input logic                          timer_cancel_o,
  input logic                          timer_start_o,
  input logic [lbd_pkg::WAIT_W-1:0]    next_wait_ms_o
);

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(led_drive_o)
      && $stable(led_state_o) && $stable(next_wait_ms_o) && $stable(timer_cancel_o))
    else $error("result item changed while stalled");

  // Timer restart flag follows the wait
  a_start_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (timer_start_o == (next_wait_ms_o != '0)))
    else $error("timer_start disagrees with next_wait_ms");

  // Cancel and start never come in one item: only update reports a wait, only blink cancels
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(timer_cancel_o && timer_start_o))
    else $error("cancel and start in one item");

  // A lit pin is always remembered as lit
  a_drive_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((led_drive_o & ~led_state_o) == '0))
    else $error("pin driven without state bit");

  // Input backs up only behind a full, stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

endmodule

bind led_blink_duty_controller lbd_checker #(
  .NUM_LEDS (NUM_LEDS)
) u_lbd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .led_drive_o    (led_drive_o),
  .led_state_o    (led_state_o),
  .timer_cancel_o (timer_cancel_o),
  .timer_start_o  (timer_start_o),
  .next_wait_ms_o (next_wait_ms_o)
);

// ===== dv/led_blink_duty_controller_test.sv =====
// Self-checking testbench for the LED blink duty controller with its own item-level predictor.
`timescale 1ns / 100ps

module led_blink_duty_controller_test;

  localparam int          NUM_LEDS     = 3;
  localparam logic [2:0]  ALL_LEDS     = 3'b111;
  localparam logic [2:0]  MODE_OFF     = 3'b000;
  localparam logic [2:0]  MODE_ON      = 3'b001;
  localparam logic [2:0]  MODE_BLINK   = 3'b010;
  localparam logic [2:0]  MODE_CONT    = 3'b100;
  localparam logic [2:0]  FUNC_UNKNOWN = 3'd7;
  localparam logic [2:0]  SET_UNKNOWN  = 3'd7;
  localparam int unsigned STUCK_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  mask;
    logic [2:0]  mode;
    logic [7:0]  count;
    logic [7:0]  pct;
    logic [15:0] period;
    logic [31:0] now;
  } led_cmd_t;

  typedef struct packed {
    logic [2:0]  pins;
    logic [2:0]  lit;
    logic        cancel;
    logic        start;
    logic [15:0] wait_ms;
  } led_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  func_i = '0;
  logic [2:0]  led_mask_i = '0;
  logic [2:0]  set_mode_i = '0;
  logic [7:0]  blink_count_i = '0;
  logic [7:0]  duty_percent_i = '0;
  logic [15:0] period_ms_i = '0;
  logic [31:0] now_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  led_drive_o;
  logic [2:0]  led_state_o;
  logic        timer_cancel_o;
  logic        timer_start_o;
  logic [15:0] next_wait_ms_o;

  led_blink_duty_controller dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .led_mask_i     (led_mask_i),
    .set_mode_i     (set_mode_i),
    .blink_count_i  (blink_count_i),
    .duty_percent_i (duty_percent_i),
    .period_ms_i    (period_ms_i),
    .now_i          (now_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .led_drive_o    (led_drive_o),
    .led_state_o    (led_state_o),
    .timer_cancel_o (timer_cancel_o),
    .timer_start_o  (timer_start_o),
    .next_wait_ms_o (next_wait_ms_o)
  );

  // Predicted LED engine state
  logic [2:0]  lane_mode   [NUM_LEDS];
  logic [7:0]  cycles_left [NUM_LEDS];
  logic [7:0]  lane_pct    [NUM_LEDS];
  logic [15:0] lane_period [NUM_LEDS];
  logic [31:0] lane_due    [NUM_LEDS];
  logic [2:0]  lit_bits    = '0;
  logic [2:0]  saved_bits  = '0;
  logic [2:0]  pin_bits    = '0;
  logic        asleep      = 1'b0;
  logic [6:0]  dflt_duty   = lbd_pkg::DUTY_RST;
  logic [15:0] dflt_period = lbd_pkg::PERIOD_RST;
  logic [7:0]  dflt_count  = lbd_pkg::COUNT_RST;

  led_res_t    awaited_outcomes [$];
  int unsigned mismatches = 0;
  int unsigned stuck_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_go = 1'b0;
  logic [31:0] clock_ms = '0;

  initial begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      lane_mode[i]   = '0;
      cycles_left[i] = '0;
      lane_pct[i]    = '0;
      lane_period[i] = '0;
      lane_due[i]    = '0;
    end
  end

  always #1 clk_i = ~clk_i;

  // Update pin levels and remembered bits for the given LEDs
  function automatic void apply_level(logic [2:0] bits, logic [2:0] m);
    if (m == MODE_ON) pin_bits |= bits; else pin_bits &= ~bits;
    if (m != MODE_OFF) lit_bits |= bits; else lit_bits &= ~bits;
  endfunction

  // Plain off, on or toggle of the masked LEDs
  function automatic void set_level(logic [2:0] mask, logic [2:0] how);
    for (int i = 0; i < NUM_LEDS; i++) begin
      if (mask[i]) begin
        if (how == lbd_pkg::SM_TOGGLE) lane_mode[i] ^= MODE_ON;
        else lane_mode[i] = (how == lbd_pkg::SM_ON) ? MODE_ON : MODE_OFF;
        apply_level(3'(1 << i), lane_mode[i]);
      end
    end
  endfunction

  // Start blinking; returns the timer cancel flag
  function automatic logic start_blink(logic [2:0] mask, logic [7:0] count, logic [7:0] pct,
                                       logic [15:0] period, logic [31:0] now);
    logic started;
    started = 1'b0;
    if (mask == 3'b000 || pct == 8'd0 || period == 16'd0) begin
      set_level(mask, lbd_pkg::SM_OFF);
    end else if (pct >= 8'd100) begin
      set_level(mask, lbd_pkg::SM_ON);
    end else begin
      started = 1'b1;
      for (int i = 0; i < NUM_LEDS; i++) begin
        if (mask[i]) begin
          if (lane_mode[i] < MODE_BLINK) saved_bits[i] = saved_bits[i] | lit_bits[i];
          lane_mode[i]   = MODE_BLINK | ((count == 8'd0) ? MODE_CONT : MODE_OFF);
          lane_period[i] = period;
          lane_pct[i]    = pct;
          cycles_left[i] = count;
          lane_due[i]    = now;
        end
      end
    end
    return started;
  endfunction

  // Advance every blinking LED to time now; returns the shortest wait
  function automatic logic [15:0] advance_blinks(logic [31:0] now);
    logic [15:0] best;
    logic [15:0] step;
    logic [31:0] share;
    logic [31:0] left;
    logic [2:0]  bit_i;
    best = '0;
    if (!asleep) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        bit_i = 3'(1 << i);
        if (lane_mode[i][1]) begin
          share = '0;
          if (now >= lane_due[i]) begin
            if (lane_mode[i][0]) begin
              share = 32'd100 - 32'(lane_pct[i]);
              lane_mode[i][0] = 1'b0;
              apply_level(bit_i, MODE_OFF);
              if (!lane_mode[i][2]) cycles_left[i] = cycles_left[i] - 8'd1;
            end else if (cycles_left[i] == 8'd0 && !lane_mode[i][2]) begin
              lane_mode[i][1] = 1'b0;
            end else begin
              share = 32'(lane_pct[i]);
              lane_mode[i][0] = 1'b1;
              apply_level(bit_i, MODE_ON);
            end
            if (lane_mode[i][1]) begin
              left = (share * 32'(lane_period[i])) / 32'd100;
              step = (left > 32'd65535) ? lbd_pkg::WAIT_MAX : left[15:0];
              lane_due[i] = now + 32'(step);
            end else begin
              // blink finished: go back to the level held before blinking
              step = '0;
              set_level(bit_i, saved_bits[i] ? lbd_pkg::SM_ON : lbd_pkg::SM_OFF);
              saved_bits[i] = 1'b0;
            end
          end else begin
            left = lane_due[i] - now;
            step = (left > 32'd65535) ? lbd_pkg::WAIT_MAX : left[15:0];
          end
          if (best == 16'd0 || (step != 16'd0 && step < best)) best = step;
        end
      end
    end
    return best;
  endfunction

  // Expected result for one accepted item
  function automatic led_res_t predict_outcome(led_cmd_t c);
    led_res_t r;
    logic     cancel;
    logic [15:0] w;
    cancel = 1'b0;
    w = '0;
    case (c.func)
      lbd_pkg::FUNC_SET: begin
        if (c.mode <= lbd_pkg::SM_TOGGLE) set_level(c.mask, c.mode);
        else if (c.mode == lbd_pkg::SM_BLINK)
          cancel = start_blink(c.mask, 8'd1, {1'b0, dflt_duty}, dflt_period, c.now);
        else if (c.mode == lbd_pkg::SM_FLASH)
          cancel = start_blink(c.mask, dflt_count, {1'b0, dflt_duty}, dflt_period, c.now);
      end
      lbd_pkg::FUNC_BLINK:  cancel = start_blink(c.mask, c.count, c.pct, c.period, c.now);
      lbd_pkg::FUNC_UPDATE: w = advance_blinks(c.now);
      lbd_pkg::FUNC_SLEEP: begin
        asleep = 1'b1;
        apply_level(ALL_LEDS, MODE_OFF);
      end
      lbd_pkg::FUNC_WAKE:   asleep = 1'b0;
      default: ;
    endcase
    r.pins    = pin_bits;
    r.lit     = lit_bits;
    r.cancel  = cancel;
    r.start   = (w != 16'd0);
    r.wait_ms = w;
    return r;
  endfunction

  function automatic led_cmd_t command(logic [2:0] func, logic [2:0] mask, logic [2:0] mode,
                                       logic [7:0] count, logic [7:0] pct,
                                       logic [15:0] period, logic [31:0] now);
    led_cmd_t c;
    c.func = func;
    c.mask = mask;
    c.mode = mode;
    c.count = count;
    c.pct = pct;
    c.period = period;
    c.now = now;
    return c;
  endfunction

  // Offer one item, hold it until accepted, then record its expected result
  task automatic send_cmd(input led_cmd_t c);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    func_i         = c.func;
    led_mask_i     = c.mask;
    set_mode_i     = c.mode;
    blink_count_i  = c.count;
    duty_percent_i = c.pct;
    period_ms_i    = c.period;
    now_i          = c.now;
    do @(posedge clk_i); while (in_stall_o);
    awaited_outcomes.push_back(predict_outcome(c));
  endtask

  // Drop valid and wait until every result is back
  task automatic drain;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_setting(input lbd_pkg::cfg_reg_e idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      lbd_pkg::CFG_DUTY:   dflt_duty = data[6:0];
      lbd_pkg::CFG_PERIOD: dflt_period = data;
      lbd_pkg::CFG_COUNT:  dflt_count = data[7:0];
      default: ;
    endcase
  endtask

  // Random item: mostly blink setups and updates on a running clock, some noise
  function automatic led_cmd_t random_cmd();
    led_cmd_t    c;
    int unsigned pick;
    logic [31:0] soonest;
    logic        found;
    c = led_cmd_t'({$urandom, $urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 2) clock_ms = $urandom;
    else clock_ms += 32'($urandom_range(0, 40));
    if (pick < 45) begin
      c.func = lbd_pkg::FUNC_UPDATE;
      c.now  = clock_ms;
      // aim at the next change of a blinking LED now and then
      if ($urandom_range(2) == 0) begin
        found = 1'b0;
        soonest = '0;
        for (int i = 0; i < NUM_LEDS; i++) begin
          if (lane_mode[i][1] && (!found || lane_due[i] < soonest)) begin
            soonest = lane_due[i];
            found = 1'b1;
          end
        end
        if (found) begin
          c.now = soonest;
          if (soonest > clock_ms) clock_ms = soonest;
        end
      end
    end else if (pick < 65) begin
      c.func   = lbd_pkg::FUNC_BLINK;
      c.mask   = 3'($urandom_range(1, 7));
      c.count  = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
      c.pct    = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 99));
      c.period = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 200));
      c.now    = clock_ms;
    end else if (pick < 80) begin
      c.func = lbd_pkg::FUNC_SET;
      c.mode = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4));
      c.now  = clock_ms;
    end else if (pick < 85) begin
      c.func = lbd_pkg::FUNC_SLEEP;
    end else if (pick < 92) begin
      c.func = lbd_pkg::FUNC_WAKE;
    end
    return c;
  endfunction

  // Result side: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_outcome
    led_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none actual drive %b state %b wait %0d",
                 $time, led_drive_o, led_state_o, next_wait_ms_o);
        mismatches++;
      end else begin
        want = awaited_outcomes.pop_front();
        flag_field("led_drive", 32'(want.pins), 32'(led_drive_o));
        flag_field("led_state", 32'(want.lit), 32'(led_state_o));
        flag_field("timer_cancel", 32'(want.cancel), 32'(timer_cancel_o));
        flag_field("timer_start", 32'(want.start), 32'(timer_start_o));
        flag_field("next_wait_ms", 32'(want.wait_ms), 32'(next_wait_ms_o));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Plain levels, unknown codes and the field extremes
  task automatic test_plain_levels;
    send_cmd(command(lbd_pkg::FUNC_SET, 3'b111, lbd_pkg::SM_ON, 8'd0, 8'd0, 16'd0, 32'd0));
    send_cmd(command(lbd_pkg::FUNC_SET, 3'b101, lbd_pkg::SM_TOGGLE, 8'd0, 8'd0, 16'd0,
                     32'd0));
    send_cmd(command(lbd_pkg::FUNC_SET, 3'b010, lbd_pkg::SM_OFF, 8'd0, 8'd0, 16'd0, 32'd0));
    send_cmd(command(lbd_pkg::FUNC_SET, 3'b111, SET_UNKNOWN, 8'hFF, 8'hFF, 16'hFFFF,
                     32'hFFFF_FFFF));
    send_cmd(command(FUNC_UNKNOWN, 3'b111, SET_UNKNOWN, 8'hFF, 8'hFF, 16'hFFFF,
                     32'hFFFF_FFFF));
    send_cmd(command(lbd_pkg::FUNC_SET, 3'b000, lbd_pkg::SM_TOGGLE, 8'd0, 8'd0, 16'd0,
                     32'd0));
  endtask

  // Blink corner cases: degenerate arguments, counted end, wrap, saturation, sleep
  task automatic test_blink_timing;
    send_cmd(command(lbd_pkg::FUNC_BLINK, 3'b000, lbd_pkg::SM_OFF, 8'd3, 8'd50, 16'd100,
                     32'd0));
    send_cmd(command(lbd_pkg::FUNC_BLINK, 3'b001, lbd_pkg::SM_OFF, 8'd3, 8'd0, 16'd100,
                     32'd0));
    send_cmd(command(lbd_pkg::FUNC_BLINK, 3'b010, lbd_pkg::SM_OFF, 8'd3, 8'd100, 16'd100,
                     32'd0));
    send_cmd(command(lbd_pkg::FUNC_BLINK, 3'b100, lbd_pkg::SM_OFF, 8'd3, 8'd255, 16'd100,
                     32'd0));
    send_cmd(command(lbd_pkg::FUNC_BLINK, 3'b001, lbd_pkg::SM_OFF, 8'd3, 8'd50, 16'd0,
                     32'd0));
    // one counted cycle from a lit LED, which must come back lit
    send_cmd(command(lbd_pkg::FUNC_SET, 3'b001, lbd_pkg::SM_ON, 8'd0, 8'd0, 16'd0, 32'd0));
    send_cmd(command(lbd_pkg::FUNC_BLINK, 3'b001, lbd_pkg::SM_OFF, 8'd1, 8'd50, 16'd10,
                     32'd0));
    send_cmd(command(lbd_pkg::FUNC_UPDATE, 3'b000, lbd_pkg::SM_OFF, 8'd0, 8'd0, 16'd0,
                     32'd0));
    send_cmd(command(lbd_pkg::FUNC_UPDATE, 3'b000, lbd_pkg::SM_OFF, 8'd0, 8'd0, 16'd0,
                     32'd5));
    send_cmd(command(lbd_pkg::FUNC_UPDATE, 3'b000, lbd_pkg::SM_OFF, 8'd0, 8'd0, 16'd0,
                     32'd10));
    // continuous blink whose next change wraps past the top of time
    send_cmd(command(lbd_pkg::FUNC_BLINK, 3'b110, lbd_pkg::SM_OFF, 8'd0, 8'd99, 16'hFFFF,
                     32'hFFFF_FFF0));
    send_cmd(command(lbd_pkg::FUNC_UPDATE, 3'b000, lbd_pkg::SM_OFF, 8'd0, 8'd0, 16'd0,
                     32'hFFFF_FFF0));
    send_cmd(command(lbd_pkg::FUNC_SET, 3'b010, lbd_pkg::SM_TOGGLE, 8'd0, 8'd0, 16'd0,
                     32'd0));
    // wait of zero, and time left beyond the wait range
    send_cmd(command(lbd_pkg::FUNC_BLINK, 3'b100, lbd_pkg::SM_OFF, 8'd3, 8'd1, 16'd1,
                     32'h8000_0000));
    send_cmd(command(lbd_pkg::FUNC_UPDATE, 3'b000, lbd_pkg::SM_OFF, 8'd0, 8'd0, 16'd0,
                     32'h0000_0010));
    send_cmd(command(lbd_pkg::FUNC_UPDATE, 3'b000, lbd_pkg::SM_OFF, 8'd0, 8'd0, 16'd0,
                     32'h8000_0000));
    send_cmd(command(lbd_pkg::FUNC_SET, 3'b001, lbd_pkg::SM_BLINK, 8'd0, 8'd0, 16'd0,
                     32'h8000_0000));
    send_cmd(command(lbd_pkg::FUNC_SET, 3'b100, lbd_pkg::SM_FLASH, 8'd0, 8'd0, 16'd0,
                     32'h8000_0000));
    send_cmd(command(lbd_pkg::FUNC_UPDATE, 3'b000, lbd_pkg::SM_OFF, 8'd0, 8'd0, 16'd0,
                     32'h8000_0000));
    send_cmd(command(lbd_pkg::FUNC_SLEEP, 3'b000, lbd_pkg::SM_OFF, 8'd0, 8'd0, 16'd0,
                     32'd0));
    send_cmd(command(lbd_pkg::FUNC_UPDATE, 3'b000, lbd_pkg::SM_OFF, 8'd0, 8'd0, 16'd0,
                     32'h9000_0000));
    send_cmd(command(lbd_pkg::FUNC_WAKE, 3'b000, lbd_pkg::SM_OFF, 8'd0, 8'd0, 16'd0,
                     32'd0));
    send_cmd(command(lbd_pkg::FUNC_SET, 3'b111, lbd_pkg::SM_OFF, 8'd0, 8'd0, 16'd0, 32'd0));
  endtask

  // Default blink and flash under several register settings, extremes included
  task automatic test_defaults;
    logic [15:0] duty_set   [6] = '{16'd1, 16'd99, 16'd0, 16'd127, 16'hFFE3, 16'd5};
    logic [15:0] period_set [6] = '{16'd1, 16'hFFFF, 16'd1000, 16'd500, 16'd37, 16'd1000};
    logic [15:0] count_set  [6] = '{16'd0, 16'd255, 16'd1, 16'd50, 16'hFF02, 16'd50};
    for (int s = 0; s < 6; s++) begin
      drain();
      write_setting(lbd_pkg::CFG_DUTY, duty_set[s]);
      write_setting(lbd_pkg::CFG_PERIOD, period_set[s]);
      write_setting(lbd_pkg::CFG_COUNT, count_set[s]);
      send_cmd(command(lbd_pkg::FUNC_SET, 3'b001, lbd_pkg::SM_BLINK, 8'd0, 8'd0, 16'd0,
                       clock_ms));
      send_cmd(command(lbd_pkg::FUNC_SET, 3'b110, lbd_pkg::SM_FLASH, 8'd0, 8'd0, 16'd0,
                       clock_ms));
      for (int k = 0; k < 4; k++) begin
        clock_ms += 32'(period_set[s] / 2);
        send_cmd(command(lbd_pkg::FUNC_UPDATE, 3'b000, lbd_pkg::SM_OFF, 8'd0, 8'd0, 16'd0,
                         clock_ms));
      end
    end
  endtask

  // Random traffic under one idling pattern, with fresh register values
  task automatic test_random_traffic(input int unsigned sidle, input int unsigned ridle,
                                     input int unsigned count);
    drain();
    write_setting(lbd_pkg::CFG_DUTY, 16'($urandom_range(1, 99)));
    write_setting(lbd_pkg::CFG_PERIOD, ($urandom_range(3) == 0) ? 16'($urandom) :
                                                                  16'($urandom_range(1, 200)));
    write_setting(lbd_pkg::CFG_COUNT, 16'($urandom_range(0, 6)));
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int n = 0; n < count; n++) send_cmd(random_cmd());
  endtask

  // Long result hold-off while items keep coming, so the block fills and stalls
  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go = 1'b1;
    for (int n = 0; n < 40; n++) send_cmd(random_cmd());
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    test_plain_levels();
    test_blink_timing();
    test_defaults();
    test_random_traffic(24, 84, 520);
    test_random_traffic(84, 24, 520);
    test_random_traffic(0, 0, 480);
    test_backpressure();
    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
